FILE: rtl/slu_pkg.sv
// Shared types and constants for the sorted list union merge block.
// Used by the controller, the datapath, the top level and the checker.
package slu_pkg;

  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IN_WIDTH   = 32;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_APPEND_A = 2'd0,
    KIND_APPEND_B = 2'd1,
    KIND_MERGE    = 2'd2
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic append_a;
    logic append_b;
    logic start;
    logic emit;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic both_empty;
    logic last_pick;
  } sts_t;

  function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [IN_WIDTH-1:0] v);
    logic signed [DATA_WIDTH-1:0] r;
    r = DATA_WIDTH'(v);
    return r;
  endfunction

  function automatic logic [IN_WIDTH-1:0] to_out(input logic signed [DATA_WIDTH-1:0] v);
    logic signed [IN_WIDTH-1:0] r;
    r = IN_WIDTH'(v);
    return r;
  endfunction

endpackage

FILE: rtl/slu_ctrl.sv
// Sequencer for appends and merge runs.
// Depends on slu_pkg; drives commands into slu_datapath and reads its status.
module slu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_kind_i,
  input  slu_pkg::sts_t sts_i,
  output slu_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (slu_pkg::kind_e'(in_kind_i))
            slu_pkg::KIND_APPEND_A: cmd_o.append_a = 1'b1;
            slu_pkg::KIND_APPEND_B: cmd_o.append_b = 1'b1;
            slu_pkg::KIND_MERGE: begin
              cmd_o.start = 1'b1;
              state_d     = ST_READ;
            end
            default: ;
          endcase
        end
      end
      // heads are fetched from both buffers during this cycle
      ST_READ: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.both_empty || sts_i.last_pick) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/slu_datapath.sv
// List buffers, counts, merge pointers, head compare and the output register.
// Depends on slu_pkg; commanded by slu_ctrl.
module slu_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  slu_pkg::cmd_t                        cmd_i,
  output slu_pkg::sts_t                        sts_o,
  input  logic signed [slu_pkg::IN_WIDTH-1:0]  in_value_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic signed [slu_pkg::IN_WIDTH-1:0]  out_value_res_o,
  output logic                                 out_last_o,
  output logic                                 out_empty_res_o,
  output logic                                 out_overflow_o
);

  logic [slu_pkg::DATA_WIDTH-1:0] mem_a [slu_pkg::LIST_DEPTH];
  logic [slu_pkg::DATA_WIDTH-1:0] mem_b [slu_pkg::LIST_DEPTH];

  logic [slu_pkg::CNT_W-1:0]      cnt_a_q, cnt_b_q;
  logic [slu_pkg::CNT_W-1:0]      ptr_a_q, ptr_b_q;
  logic [slu_pkg::CNT_W-1:0]      ptr_a_d, ptr_b_d;
  logic                           dropped_q;
  logic [slu_pkg::DATA_WIDTH-1:0] head_a_q, head_b_q;

  logic                           out_valid_q;
  logic [slu_pkg::IN_WIDTH-1:0]   out_value_q;
  logic                           out_last_q, out_empty_q, out_ovf_q;

  logic                           full_a, full_b;
  logic                           has_a, has_b;
  logic                           take_a, take_b;
  logic [slu_pkg::DATA_WIDTH-1:0] pick;

  localparam logic [slu_pkg::CNT_W-1:0] DEPTH_C = slu_pkg::CNT_W'(slu_pkg::LIST_DEPTH);

  assign full_a = (cnt_a_q >= DEPTH_C);
  assign full_b = (cnt_b_q >= DEPTH_C);
  assign has_a  = (ptr_a_q < cnt_a_q);
  assign has_b  = (ptr_b_q < cnt_b_q);

  // Pick the smaller head; equal heads advance both lists
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    pick   = head_a_q;
    priority if (has_a && has_b) begin
      if ($signed(head_a_q) < $signed(head_b_q)) begin
        take_a = 1'b1;
      end else if ($signed(head_b_q) < $signed(head_a_q)) begin
        take_b = 1'b1;
        pick   = head_b_q;
      end else begin
        take_a = 1'b1;
        take_b = 1'b1;
      end
    end else if (has_a) begin
      take_a = 1'b1;
    end else if (has_b) begin
      take_b = 1'b1;
      pick   = head_b_q;
    end else begin
      take_a = 1'b0;
      take_b = 1'b0;
    end
  end

  assign ptr_a_d = ptr_a_q + slu_pkg::CNT_W'(take_a);
  assign ptr_b_d = ptr_b_q + slu_pkg::CNT_W'(take_b);

  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
  assign sts_o.last_pick  = (ptr_a_d >= cnt_a_q) && (ptr_b_d >= cnt_b_q);

  // Buffers: write on append, read the current heads every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.append_a && !full_a) begin
      mem_a[cnt_a_q[slu_pkg::IDX_W-1:0]] <= slu_pkg::to_store(in_value_i);
    end
    if (cmd_i.append_b && !full_b) begin
      mem_b[cnt_b_q[slu_pkg::IDX_W-1:0]] <= slu_pkg::to_store(in_value_i);
    end
    head_a_q <= mem_a[ptr_a_q[slu_pkg::IDX_W-1:0]];
    head_b_q <= mem_b[ptr_b_q[slu_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      ptr_a_q   <= '0;
      ptr_b_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      if (cmd_i.append_a) begin
        if (full_a) begin
          dropped_q <= 1'b1;
        end else begin
          cnt_a_q <= cnt_a_q + slu_pkg::CNT_W'(1);
        end
      end
      if (cmd_i.append_b) begin
        if (full_b) begin
          dropped_q <= 1'b1;
        end else begin
          cnt_b_q <= cnt_b_q + slu_pkg::CNT_W'(1);
        end
      end
      if (cmd_i.start) begin
        ptr_a_q <= '0;
        ptr_b_q <= '0;
      end else if (cmd_i.emit) begin
        ptr_a_q <= ptr_a_d;
        ptr_b_q <= ptr_b_d;
      end
      if (cmd_i.finish) begin
        cnt_a_q   <= '0;
        cnt_b_q   <= '0;
        dropped_q <= 1'b0;
      end
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_ovf_q <= dropped_q;
      if (sts_o.both_empty) begin
        out_value_q <= '0;
        out_last_q  <= 1'b1;
        out_empty_q <= 1'b1;
      end else begin
        out_value_q <= slu_pkg::to_out(pick);
        out_last_q  <= sts_o.last_pick;
        out_empty_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_value_res_o = out_value_q;
  assign out_last_o      = out_last_q;
  assign out_empty_res_o = out_empty_q;
  assign out_overflow_o  = out_ovf_q;

endmodule

FILE: rtl/sorted_list_union_merge.sv
// Top level of the sorted list union merge block.
// Depends on slu_pkg, slu_ctrl and slu_datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | in_kind_i, in_value_i
//  out     | source    | out_valid_o / out_stall_i| out_value_res_o, out_last_o,
//          |           |                          | out_empty_res_o, out_overflow_o
//
// An append request leaves the block idle, so it is ready again in the next cycle.
// For each result, a merge request reads the heads from the buffers and then compares them and
// loads the output register; a run on two empty lists gives a single empty result.
// Requests are stalled for the whole of a merge run.
// A stall on the output holds the run at its next result.
// Reset clears both lists and the overflow flag; buffer contents are not cleared.
module sorted_list_union_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          in_kind_i,
  input  logic signed [slu_pkg::IN_WIDTH-1:0] in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [slu_pkg::IN_WIDTH-1:0] out_value_res_o,
  output logic                                out_last_o,
  output logic                                out_empty_res_o,
  output logic                                out_overflow_o
);

  slu_pkg::cmd_t cmd;
  slu_pkg::sts_t sts;

  slu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  slu_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_value_i      (in_value_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_value_res_o (out_value_res_o),
    .out_last_o      (out_last_o),
    .out_empty_res_o (out_empty_res_o),
    .out_overflow_o  (out_overflow_o)
  );

endmodule

FILE: rtl/slu_checker.sv
// Port-level checks for sorted_list_union_merge, attached by the bind below.
// Depends on slu_pkg for the request kind codes and the value width.
module slu_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [1:0]                          in_kind_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [slu_pkg::IN_WIDTH-1:0] out_value_res_o,
  input logic                                out_last_o,
  input logic                                out_empty_res_o,
  input logic                                out_overflow_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_res_o)
      && $stable(out_last_o) && $stable(out_empty_res_o) && $stable(out_overflow_o))
    else $error("stalled result changed");

  // the empty-run result is the only one of its run, and carries zero
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_empty_res_o |-> out_last_o && (out_value_res_o == '0))
    else $error("empty result malformed");

  // a merge request blocks further requests
  a_merge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_kind_i == slu_pkg::KIND_MERGE) |=> in_stall_o)
    else $error("request taken during merge run");

  // results only come out of a merge run
  a_result_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result outside merge run");

  // appends never produce a result
  a_append_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_kind_i != slu_pkg::KIND_MERGE)
      && !(out_valid_o && out_stall_i) |=> !out_valid_o)
    else $error("append produced a result");

endmodule

bind sorted_list_union_merge slu_checker u_slu_checker (.*);

FILE: tb/sv/tb_sorted_list_union_merge.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_list_union_merge: list loads, union merge runs, overflow.
// Depends on slu_pkg and the sorted_list_union_merge RTL; needs no other files.
module tb_sorted_list_union_merge;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 105;
  localparam int         CALM_TAIL    = 30;
  localparam int         LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [1:0]                          kind;
    logic signed [slu_pkg::IN_WIDTH-1:0] value;
    bit                                  hold;
  } req_t;

  typedef struct packed {
    logic signed [slu_pkg::IN_WIDTH-1:0] value_res;
    logic                                last;
    logic                                empty_res;
    logic                                overflow;
  } union_res_t;

  logic                                clk_i;
  logic                                rst_ni    = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall_o;
  logic [1:0]                          in_kind   = '0;
  logic signed [slu_pkg::IN_WIDTH-1:0] in_value  = '0;
  logic                                out_valid_o;
  logic                                out_stall = 1'b0;
  logic signed [slu_pkg::IN_WIDTH-1:0] out_value_res_o;
  logic                                out_last_o;
  logic                                out_empty_res_o;
  logic                                out_overflow_o;

  req_t                                  pending_reqs[$];
  union_res_t                            union_expected[$];
  logic signed [slu_pkg::DATA_WIDTH-1:0] shadow_a[$];
  logic signed [slu_pkg::DATA_WIDTH-1:0] shadow_b[$];
  bit                                    shadow_dropped = 1'b0;
  bit                                    calm = 1'b0;
  int                                    fails = 0;
  int                                    counted = 0;
  int                                    cycles = 0;
  int                                    idle_left = 0;
  int                                    stall_left = 0;

  sorted_list_union_merge uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .in_kind_i       (in_kind),
    .in_value_i      (in_value),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .out_value_res_o (out_value_res_o),
    .out_last_o      (out_last_o),
    .out_empty_res_o (out_empty_res_o),
    .out_overflow_o  (out_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Update the shadow lists for one accepted request and queue the union it yields.
  task automatic predict_union(input logic [1:0] kind,
                               input logic signed [slu_pkg::IN_WIDTH-1:0] v);
    logic signed [slu_pkg::DATA_WIDTH-1:0] stored;
    logic signed [slu_pkg::DATA_WIDTH-1:0] pick;
    int                                    i;
    int                                    j;
    union_res_t                            r;
    stored = v;
    i = 0;
    j = 0;
    case (kind)
      slu_pkg::KIND_APPEND_A: begin
        if (shadow_a.size() >= int'(slu_pkg::LIST_DEPTH)) shadow_dropped = 1'b1;
        else shadow_a.insert(shadow_a.size(), stored);
      end
      slu_pkg::KIND_APPEND_B: begin
        if (shadow_b.size() >= int'(slu_pkg::LIST_DEPTH)) shadow_dropped = 1'b1;
        else shadow_b.insert(shadow_b.size(), stored);
      end
      slu_pkg::KIND_MERGE: begin
        if (shadow_a.size() == 0 && shadow_b.size() == 0) begin
          r.value_res = '0;
          r.last      = 1'b1;
          r.empty_res = 1'b1;
          r.overflow  = shadow_dropped;
          union_expected.insert(union_expected.size(), r);
        end else begin
          while (i < shadow_a.size() || j < shadow_b.size()) begin
            if (i < shadow_a.size() && j < shadow_b.size()) begin
              if (shadow_a[i] < shadow_b[j]) begin
                pick = shadow_a[i];
                i++;
              end else if (shadow_b[j] < shadow_a[i]) begin
                pick = shadow_b[j];
                j++;
              end else begin
                // equal heads: emit once, advance both
                pick = shadow_a[i];
                i++;
                j++;
              end
            end else if (i < shadow_a.size()) begin
              pick = shadow_a[i];
              i++;
            end else begin
              pick = shadow_b[j];
              j++;
            end
            r.value_res = pick;
            r.last      = (i >= shadow_a.size() && j >= shadow_b.size());
            r.empty_res = 1'b0;
            r.overflow  = shadow_dropped;
            union_expected.insert(union_expected.size(), r);
          end
        end
        shadow_a.delete();
        shadow_b.delete();
        shadow_dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic queue_req(input logic [1:0] kind,
                           input logic signed [slu_pkg::IN_WIDTH-1:0] v,
                           input bit hold);
    req_t q;
    q.kind  = kind;
    q.value = v;
    q.hold  = hold;
    pending_reqs.insert(pending_reqs.size(), q);
    if (!hold && kind != KIND_UNUSED) counted++;
  endtask

  // Ascending values spread over the lists; mode 0 mixes (some to both), 1 only A, 2 only B.
  task automatic queue_sorted_run(input int n, input bit wide, input int mode);
    longint cursor;
    int     s;
    int     c;
    if (wide) begin
      s = $urandom;
      cursor = s;
    end else begin
      cursor = longint'($urandom_range(0, 40)) - 20;
    end
    if ($urandom_range(0, 5) == 0) cursor = -64'sd2147483648;
    for (int k = 0; k < n; k++) begin
      c = (mode == 0) ? $urandom_range(0, 2) : mode - 1;
      if (c != 1) queue_req(slu_pkg::KIND_APPEND_A, cursor[slu_pkg::IN_WIDTH-1:0], 1'b0);
      if (c != 0) queue_req(slu_pkg::KIND_APPEND_B, cursor[slu_pkg::IN_WIDTH-1:0], 1'b0);
      cursor += wide ? longint'($urandom_range(0, 32'h1000_0000)) : longint'($urandom_range(0, 3));
      if (cursor > 64'sd2147483647) cursor = 64'sd2147483647;
    end
    queue_req(slu_pkg::KIND_MERGE, '0, 1'b0);
  endtask

  initial begin
    int base;
    int pick;
    int m;
    // both lists empty, then an unused kind
    queue_req(slu_pkg::KIND_MERGE, 32'sd12345, 1'b0);
    queue_req(KIND_UNUSED, 32'hA5A5_5A5A, 1'b0);
    // extremes, shared values and a shared maximum
    queue_req(slu_pkg::KIND_APPEND_A, 32'h8000_0000, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_B, -32'sd5, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_A, -32'sd5, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_A, 32'sd0, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_B, 32'sd3, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_A, 32'sd7, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_B, 32'sd7, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_A, 32'h7FFF_FFFF, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_B, 32'h7FFF_FFFF, 1'b0);
    queue_req(slu_pkg::KIND_MERGE, '1, 1'b0);
    queue_req('0, '0, 1'b1);
    // drain of the second list alone, repeated value kept
    queue_req(slu_pkg::KIND_APPEND_B, 32'sd10, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_B, 32'sd10, 1'b0);
    queue_req(slu_pkg::KIND_MERGE, '0, 1'b0);
    // drain of the first list alone
    queue_req(slu_pkg::KIND_APPEND_A, -32'sd1, 1'b0);
    queue_req(slu_pkg::KIND_APPEND_A, 32'sd5, 1'b0);
    queue_req(slu_pkg::KIND_MERGE, '0, 1'b0);
    queue_req(KIND_UNUSED, '0, 1'b0);
    queue_req(slu_pkg::KIND_MERGE, '0, 1'b0);

    base = counted;
    // fill one list to the brim or past it
    queue_sorted_run($urandom_range(32, 35), 1'($urandom_range(0, 1)), $urandom_range(1, 2));
    while (counted < base + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        queue_sorted_run($urandom_range(32, 35), 1'($urandom_range(0, 1)),
                         $urandom_range(1, 2));
      end else if (pick < 15) begin
        queue_sorted_run($urandom_range(0, 14), 1'($urandom_range(0, 1)), 0);
      end else begin
        // noise: unordered values, any kind
        m = $urandom_range(1, 8);
        for (int k = 0; k < m; k++) queue_req(2'($urandom_range(0, 3)), $urandom, 1'b0);
        if ($urandom_range(0, 1) == 0) queue_req(slu_pkg::KIND_MERGE, $urandom, 1'b0);
      end
      if ($urandom_range(0, 9) == 0) queue_req('0, '0, 1'b1);
    end
    queue_req(slu_pkg::KIND_MERGE, '0, 1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (union_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("[sorted_list_union_merge] OK");
    end else begin
      $display("[sorted_list_union_merge] ERROR");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    req_t nxt;
    bit   go;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      idle_left = 0;
    end else begin
      calm <= (pending_reqs.size() <= CALM_TAIL);
      if (in_valid && !in_stall_o) predict_union(in_kind, in_value);
      if (!in_valid || !in_stall_o) begin
        go = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          idle_left = $urandom_range(1, 9) - 1;
        end else if (pending_reqs.size() != 0) begin
          if (pending_reqs[0].hold) begin
            // hold off until every outstanding result has arrived
            if (union_expected.size() == 0) pending_reqs.delete(0);
          end else begin
            nxt = pending_reqs[0];
            pending_reqs.delete(0);
            in_kind  <= nxt.kind;
            in_value <= nxt.value;
            go = 1'b1;
          end
        end
        in_valid <= go;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    union_res_t want;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (union_expected.size() == 0) begin
          $error("unexpected result: value_res %0d last %0b", out_value_res_o, out_last_o);
          fails++;
        end else begin
          want = union_expected[0];
          union_expected.delete(0);
          if (out_value_res_o !== want.value_res) begin
            $error("value_res: expected %0d, got %0d", want.value_res, out_value_res_o);
            fails++;
          end
          if (out_last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last_o);
            fails++;
          end
          if (out_empty_res_o !== want.empty_res) begin
            $error("empty_res: expected %0b, got %0b", want.empty_res, out_empty_res_o);
            fails++;
          end
          if (out_overflow_o !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_overflow_o);
            fails++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[sorted_list_union_merge] ERROR");
      $finish;
    end
  end

endmodule

FILE: files.f
rtl/slu_pkg.sv
rtl/slu_ctrl.sv
rtl/slu_datapath.sv
rtl/sorted_list_union_merge.sv
rtl/slu_checker.sv
tb/sv/tb_sorted_list_union_merge.sv
